// File: rtl/kli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int CH_COUNT     = 6;
  localparam int VAL_W        = 32;
  localparam int FRM_W        = 16;
  localparam int SLOT_W       = 4;
  localparam int NK_W         = 5;
  localparam int DIFF_W       = VAL_W + 1;
  localparam int PROD_W       = DIFF_W + FRM_W;
  localparam int CH_W         = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;
  localparam int MAX_KEYS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_KEYS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN  = 1'b1;

  localparam logic [NK_W-1:0] NUM_KEYS_RST = 5'd2;
  localparam logic [CH_W-1:0] CH_LAST      = 3'd5;

  typedef struct packed {
    logic [CH_COUNT-1:0][VAL_W-1:0] val;
    logic [FRM_W-1:0]               frames;
  } key_row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_BASE,
    S_DIFF,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ACC,
    S_DONE
  } kli_state_t;

  typedef struct packed {
    logic rd_en;
    logic rd_other;
    logic ld_tick;
    logic cap_base;
    logic ld_diff;
    logic ld_prod;
    logic div_start;
    logic ld_res;
    logic ld_out;
  } kli_ctl_t;

endpackage

// File: rtl/keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top
// Key pose table with per-frame linear interpolation over six channels.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A write item
//   (in_req_type = 1) stores one key slot in the accept cycle, gives no
//   result, and leaves busy low. A tick item (in_req_type = 0) raises busy
//   and produces exactly one result, shown for one cycle with out_valid.
//   Per channel: diff, magnitude times frame count on the shared multiplier,
//   then the shared bit-serial divider, then the add to the base.
//   An out-of-range tick (key index not below the key count) skips the
//   key reads and channel steps and goes straight to the result.
//   The divider sets the rate; a new item may be taken in the out_valid
//   cycle. Result ports hold until the next tick result.
//   The cfg_ port writes num_keys (index 0) and loop_enable (index 1);
//   write only while idle.
//   Reset (rst_n low, synchronous) clears the key index, frame count and
//   registers to num_keys = 2, loop_enable = 0; the key table is not
//   cleared, and slots must be written before ticks read them.
//   The receiver cannot stall: out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top
  import kli_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [SLOT_W-1:0]     in_key_slot,
  input  logic signed [VAL_W-1:0] in_pos_x,
  input  logic signed [VAL_W-1:0] in_pos_y,
  input  logic signed [VAL_W-1:0] in_pos_z,
  input  logic signed [VAL_W-1:0] in_rot_x,
  input  logic signed [VAL_W-1:0] in_rot_y,
  input  logic signed [VAL_W-1:0] in_rot_z,
  input  logic [FRM_W-1:0]      in_frames,
  output logic                  out_valid,
  output logic signed [VAL_W-1:0] out_pos_x,
  output logic signed [VAL_W-1:0] out_pos_y,
  output logic signed [VAL_W-1:0] out_pos_z,
  output logic signed [VAL_W-1:0] out_rot_x,
  output logic signed [VAL_W-1:0] out_rot_y,
  output logic signed [VAL_W-1:0] out_rot_z,
  output logic                  out_updated,
  output logic                  out_motion_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW    = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int NW    = (CNT_W > NK_W) ? CNT_W : NK_W;
  localparam int SW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // configuration
  logic [NK_W-1:0] num_keys_r;
  logic            loop_en_r;

  // sequencer and motion state
  kli_state_t state_r, state_nxt;
  kli_ctl_t   ctl;
  logic [KW-1:0]    key_index_r;
  logic [FRM_W-1:0] frame_count_r;
  logic             in_range_r;
  logic             last_r;
  logic [KW-1:0]    other_r;
  logic [CH_W-1:0]  ch_r;
  logic             out_valid_r;

  // datapath
  key_row_t                       base_r;
  logic [DIFF_W-1:0]              mag_r;
  logic                           neg_r;
  logic [PROD_W-1:0]              prod_r;
  logic [CH_COUNT-1:0][VAL_W-1:0] res_r;
  logic [CH_COUNT-1:0][VAL_W-1:0] out_pose_r;
  logic                           out_updated_r;
  logic                           out_end_r;

  // index checks
  logic [NW-1:0] n_eff;
  logic [NW-1:0] k_ext;
  logic          in_range;
  logic          last_key;
  logic [KW-1:0] other_key;
  logic          accept;
  logic          accept_tick;

  // key table ports
  logic [SW-1:0] slot_ext;
  logic          mem_we;
  key_row_t      mem_wdata;
  logic [KW-1:0] mem_raddr;
  key_row_t      mem_rdata;

  // arithmetic
  logic [VAL_W-1:0]  base_val;
  logic [VAL_W-1:0]  oth_val;
  logic [DIFF_W-1:0] diff;
  logic [VAL_W-1:0]  term;
  logic              div_busy;
  logic              div_done;
  logic [VAL_W-1:0]  div_q;
  logic [FRM_W:0]    fc_inc;
  logic              seg_end;

  assign accept      = start && !busy;
  assign accept_tick = accept && !in_req_type;

  assign n_eff = (NW'(num_keys_r) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(num_keys_r);
  assign k_ext    = NW'(key_index_r);
  assign in_range = k_ext < n_eff;
  assign last_key = k_ext == (n_eff - NW'(1));

  always_comb begin
    if (!last_key) begin
      other_key = key_index_r + KW'(1);
    end else if (key_index_r == '0) begin
      other_key = '0;
    end else begin
      other_key = key_index_r - KW'(1);
    end
  end

  // key table write
  assign slot_ext         = SW'(in_key_slot);
  assign mem_we           = accept && in_req_type && (slot_ext < SW'(MAX_KEYS));
  assign mem_wdata.val    = {in_rot_z, in_rot_y, in_rot_x, in_pos_z, in_pos_y, in_pos_x};
  assign mem_wdata.frames = in_frames;
  assign mem_raddr        = ctl.rd_other ? other_r : key_index_r;

  kli_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (KW)
  ) u_key_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (KW'(slot_ext)),
    .wdata (mem_wdata),
    .re    (ctl.rd_en),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kli_div #(
    .DVD_W (PROD_W),
    .DVS_W (FRM_W),
    .Q_W   (VAL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (prod_r),
    .divisor  (base_r.frames),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept_tick) begin
          state_nxt = in_range ? S_RD_BASE : S_DONE;
        end
      end
      S_RD_BASE:  state_nxt = S_DIFF;
      S_DIFF:     state_nxt = S_MUL;
      S_MUL:      state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC:      state_nxt = (ch_r == CH_LAST) ? S_DONE : S_DIFF;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        ctl.ld_tick = accept_tick;
        ctl.rd_en   = accept_tick && in_range;
      end
      S_RD_BASE: begin
        ctl.cap_base = 1'b1;
        ctl.rd_en    = 1'b1;
        ctl.rd_other = 1'b1;
      end
      S_DIFF:     ctl.ld_diff   = 1'b1;
      S_MUL:      ctl.ld_prod   = 1'b1;
      S_DIV_GO:   ctl.div_start = 1'b1;
      S_DIV_WAIT: ctl = '0;
      S_ACC:      ctl.ld_res    = 1'b1;
      S_DONE:     ctl.ld_out    = 1'b1;
      default:    ctl = '0;
    endcase
  end

  // per-channel arithmetic
  assign base_val = base_r.val[ch_r];
  assign oth_val  = mem_rdata.val[ch_r];
  assign diff     = {oth_val[VAL_W-1], oth_val} - {base_val[VAL_W-1], base_val};
  assign term     = (base_r.frames == '0) ? '0 : (neg_r ? (VAL_W'(0) - div_q) : div_q);

  assign fc_inc  = {1'b0, frame_count_r} + (FRM_W+1)'(1);
  assign seg_end = fc_inc >= {1'b0, base_r.frames};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_keys_r    <= NUM_KEYS_RST;
      loop_en_r     <= 1'b0;
      key_index_r   <= '0;
      frame_count_r <= '0;
      ch_r          <= '0;
      out_valid_r   <= 1'b0;
      in_range_r    <= 1'b0;
      last_r        <= 1'b0;
      other_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.ld_out;
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_KEYS: num_keys_r <= cfg_wdata;
          REG_LOOP_EN:  loop_en_r  <= cfg_wdata[0];
          default:      num_keys_r <= num_keys_r;
        endcase
      end
      if (ctl.ld_tick) begin
        in_range_r <= in_range;
        last_r     <= last_key;
        other_r    <= other_key;
        ch_r       <= '0;
      end else if (ctl.ld_res) begin
        ch_r <= ch_r + CH_W'(1);
      end
      if (ctl.ld_out && in_range_r) begin
        if (seg_end) begin
          frame_count_r <= '0;
          key_index_r   <= last_r ? '0 : key_index_r + KW'(1);
        end else begin
          frame_count_r <= fc_inc[FRM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_base) begin
      base_r <= mem_rdata;
    end
    if (ctl.ld_diff) begin
      neg_r <= diff[DIFF_W-1];
      mag_r <= diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
    end
    if (ctl.ld_prod) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(frame_count_r);
    end
    if (ctl.ld_res) begin
      res_r[ch_r] <= base_val + term;
    end
    if (ctl.ld_out) begin
      out_pose_r    <= in_range_r ? res_r : '0;
      out_updated_r <= in_range_r;
      out_end_r     <= in_range_r && last_r && seg_end && !loop_en_r;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_pose_r[0];
  assign out_pos_y      = out_pose_r[1];
  assign out_pos_z      = out_pose_r[2];
  assign out_rot_x      = out_pose_r[3];
  assign out_rot_y      = out_pose_r[4];
  assign out_rot_z      = out_pose_r[5];
  assign out_updated    = out_updated_r;
  assign out_motion_end = out_end_r;

  // checks
  ap_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_updated) |-> (out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0 &&
      out_rot_x == '0 && out_rot_y == '0 && out_rot_z == '0 && !out_motion_end))
    else $error("out-of-range tick gave nonzero result");

  ap_end_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motion_end) |-> (key_index_r == '0 && frame_count_r == '0 && !loop_en_r))
    else $error("motion end without wrap to first key");

  ap_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT) |-> (div_busy || div_done))
    else $error("waiting on idle divider");

  ap_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid) && !busy)
    else $error("result strobe repeated or block busy at result");

endmodule

// File: rtl/kli_key_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_key_mem
// Key pose table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kli_key_mem
  import kli_pkg::*;
#(
  parameter int DEPTH = MAX_KEYS_DEF,
  parameter int AW    = $clog2(MAX_KEYS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  key_row_t      wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output key_row_t      rdata
);

  key_row_t mem_r [DEPTH];
  key_row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/kli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kli_div
  import kli_pkg::*;
#(
  parameter int DVD_W = PROD_W,
  parameter int DVS_W = FRM_W,
  parameter int Q_W   = VAL_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_dif;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r[Q_W-1:0];

endmodule
